// ----- hw/rtl/c128d_pkg.sv -----
// ----------------------------------------------------------------------------
// Code 128 symbol decoder package
// Shared types, symbol codes, result kinds and the constant tables used for
// set C digit splitting and the modulo 103 check sum.
// ----------------------------------------------------------------------------
package c128d_pkg;

  // Kind of one result transaction.
  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_OK      = 3'd1,
    KIND_BAD_SUM = 3'd2,
    KIND_ILLEGAL = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_t;

  // Active code set.
  typedef enum logic [1:0] {
    SET_A = 2'd0,
    SET_B = 2'd1,
    SET_C = 2'd2
  } code_set_t;

  // One entry of the result buffer.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } slot_t;

  localparam int CHECK_MOD = 103;

  // Symbol values.
  localparam logic [6:0] SYM_SHIFT   = 7'd98;
  localparam logic [6:0] SYM_CODE_C  = 7'd99;
  localparam logic [6:0] SYM_CODE_B  = 7'd100;  // in sets A and C
  localparam logic [6:0] SYM_FNC4_B  = 7'd100;  // in set B
  localparam logic [6:0] SYM_CODE_A  = 7'd101;  // in sets B and C
  localparam logic [6:0] SYM_FNC4_A  = 7'd101;  // in set A
  localparam logic [6:0] SYM_FNC1    = 7'd102;
  localparam logic [6:0] SYM_START_A = 7'd103;
  localparam logic [6:0] SYM_START_C = 7'd105;
  localparam logic [6:0] SYM_STOP    = 7'd106;
  localparam logic [6:0] SYM_MAX_C   = 7'd102;

  // Character bytes produced by the decoder.
  localparam logic [7:0] BYTE_GS     = 8'h1D;
  localparam logic [7:0] BYTE_BRACKET = 8'h5D;
  localparam logic [7:0] BYTE_UPPER_C = 8'h43;
  localparam logic [7:0] BYTE_ONE    = 8'h31;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;

  typedef logic [6:0] mod_tab_t [128];
  typedef logic [7:0] digit_tab_t [128];

  // (h * 128) mod 103, used to fold the upper bits of a product.
  function automatic mod_tab_t hi_mod_table();
    mod_tab_t t;
    for (int h = 0; h < 128; h++) begin
      t[h] = 7'((h * 128) % CHECK_MOD);
    end
    return t;
  endfunction

  // Tens digit in the upper nibble, units digit in the lower one.
  function automatic digit_tab_t digit_table();
    digit_tab_t t;
    for (int d = 0; d < 128; d++) begin
      if (d < 100) begin
        t[d] = {4'(d / 10), 4'(d % 10)};
      end else begin
        t[d] = 8'h00;
      end
    end
    return t;
  endfunction

  localparam mod_tab_t   HI_MOD = hi_mod_table();
  localparam digit_tab_t DIGITS = digit_table();

  // Reduces a value below 333 modulo 103 with two compare and subtract steps.
  function automatic logic [6:0] mod103_fold(input logic [8:0] x);
    logic [8:0] r;
    r = x;
    if (r >= 9'd206) begin
      r = r - 9'd206;
    end
    if (r >= 9'd103) begin
      r = r - 9'd103;
    end
    return r[6:0];
  endfunction

endpackage

// ----- hw/rtl/code128_symbol_decoder.sv -----
// ----------------------------------------------------------------------------
// Code 128 symbol decoder
// Turns a stream of Code 128 symbol values into character bytes and a final
// status transaction per symbol, with code set, shift, FNC4 and GS1 handling.
// ----------------------------------------------------------------------------
// Each symbol value is decoded in the cycle in which its transaction is
// accepted, and the result transactions that it causes are loaded into a
// four-entry result buffer that drains one transaction per cycle on the
// output channel while out_ready is high. A symbol that gives no result
// leaves the buffer free for the next one; after one that gives results, a
// new symbol is taken in the same cycle as the last of those results leaves,
// so the sustained rate of symbols is bounded by the single output
// port. The bytes of the latest data code are held back, because at the stop
// code that code turns out to be the check character: it is dropped at stop
// when it was printable and passed on otherwise. The weighted check sum uses
// one 7 by 7 bit multiplier whose product is registered and folded modulo 103
// when the next code arrives. The configuration register gs1_mode may only be
// written while the block is idle; with it set, FNC1 gives "]C1" at the start
// of the data and a group separator byte after that.
// ----------------------------------------------------------------------------
module code128_symbol_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [6:0] symbol_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] kind,
  output logic       last
);

  // Decoder state.
  logic                  gs1_mode;
  logic                  active, active_next;
  c128d_pkg::code_set_t  code_set, code_set_next;
  logic                  unshift_pending, unshift_pending_next;
  logic                  upper_latched, upper_latched_next;
  logic                  upper_one_shot, upper_one_shot_next;
  logic [6:0]            weight_mod, weight_mod_next;
  logic [6:0]            sum_before_last, sum_before_last_next;
  logic [6:0]            previous_value, previous_value_next;
  logic [13:0]           prod_last, prod_last_next;
  logic [7:0]            held_bytes [3];
  logic [7:0]            held_bytes_next [3];
  logic [1:0]            held_count, held_count_next;
  logic                  held_printable, held_printable_next;
  logic                  any_output, any_output_next;

  // Result buffer: entry 0 is the one shown on the output port.
  c128d_pkg::slot_t      slots [4];
  c128d_pkg::slot_t      slots_next [4];
  logic [2:0]            count, count_next;
  logic                  load;

  // Decode helpers.
  logic                  in_fire;
  logic                  out_fire;
  logic [6:0]            c;
  logic                  is_start;
  logic                  is_illegal;
  logic                  emit_status;
  c128d_pkg::kind_t      status_kind;
  logic [1:0]            nflush;
  logic                  flush;
  logic                  char_en;
  logic [6:0]            char_base;
  logic                  digits_en;
  logic                  fnc1_en;
  logic                  fnc4_en;
  logic [1:0]            hold_n;
  logic [7:0]            hb0, hb1, hb2;
  logic [7:0]            digit_pair;
  logic [6:0]            sum_fold;

  assign c         = symbol_value;
  assign cfg_ready = 1'b1;
  assign out_valid = (count != 3'd0);
  assign last      = (count == 3'd1);
  assign out_byte  = slots[0].data;
  assign kind      = slots[0].kind;

  // The buffer must be empty, or emptying now, before the next symbol loads it.
  assign in_ready  = (count == 3'd0) || ((count == 3'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign is_start   = (c >= c128d_pkg::SYM_START_A) && (c <= c128d_pkg::SYM_START_C);
  assign is_illegal = (c >= c128d_pkg::SYM_START_A) && (c != c128d_pkg::SYM_STOP);

  assign digit_pair = c128d_pkg::DIGITS[c];

  // Check sum contribution of the previous latest code, folded modulo 103.
  assign sum_fold = c128d_pkg::mod103_fold(9'(prod_last[6:0])
                    + 9'(c128d_pkg::HI_MOD[prod_last[13:7]])
                    + 9'(sum_before_last));

  always_comb begin
    active_next          = active;
    code_set_next        = code_set;
    unshift_pending_next = unshift_pending;
    upper_latched_next   = upper_latched;
    upper_one_shot_next  = upper_one_shot;
    weight_mod_next      = weight_mod;
    sum_before_last_next = sum_before_last;
    previous_value_next  = previous_value;
    prod_last_next       = prod_last;
    held_bytes_next      = held_bytes;
    held_count_next      = held_count;
    held_printable_next  = held_printable;
    any_output_next      = any_output;
    emit_status          = 1'b0;
    status_kind          = c128d_pkg::KIND_OK;
    flush                = 1'b0;
    char_en              = 1'b0;
    char_base            = 7'd0;
    digits_en            = 1'b0;
    fnc1_en              = 1'b0;
    fnc4_en              = 1'b0;
    hold_n               = 2'd0;
    hb0                  = 8'd0;
    hb1                  = 8'd0;
    hb2                  = 8'd0;

    if (in_fire) begin
      if (!active) begin
        // Waiting for a start code; anything else is ignored.
        if (is_start) begin
          active_next          = 1'b1;
          code_set_next        = c128d_pkg::code_set_t'(2'(c - c128d_pkg::SYM_START_A));
          unshift_pending_next = 1'b0;
          upper_latched_next   = 1'b0;
          upper_one_shot_next  = 1'b0;
          weight_mod_next      = 7'd0;
          sum_before_last_next = c - c128d_pkg::SYM_START_A;
          previous_value_next  = 7'd0;
          prod_last_next       = 14'd0;
          held_count_next      = 2'd0;
          held_printable_next  = 1'b1;
          any_output_next      = 1'b0;
        end
      end else if (is_illegal) begin
        // A start code inside a symbol, or a value above stop.
        active_next     = 1'b0;
        held_count_next = 2'd0;
        emit_status     = 1'b1;
        status_kind     = c128d_pkg::KIND_ILLEGAL;
      end else if (c == c128d_pkg::SYM_STOP) begin
        active_next     = 1'b0;
        held_count_next = 2'd0;
        emit_status     = 1'b1;
        if (sum_before_last != previous_value) begin
          status_kind = c128d_pkg::KIND_BAD_SUM;
        end else if (!any_output) begin
          status_kind = c128d_pkg::KIND_EMPTY;
        end else begin
          // The held bytes belong to the check character; pass them on only
          // when that character was not a printable one.
          status_kind = c128d_pkg::KIND_OK;
          flush       = !held_printable;
        end
      end else begin
        // Data or function code: release what the previous code held.
        flush                = 1'b1;
        sum_before_last_next = sum_fold;
        weight_mod_next      = (weight_mod == c128d_pkg::SYM_MAX_C) ? 7'd0 : weight_mod + 7'd1;
        previous_value_next  = c;
        prod_last_next       = {7'd0, weight_mod_next} * {7'd0, c};
        unshift_pending_next = 1'b0;
        held_printable_next  = 1'b1;

        case (code_set)
          c128d_pkg::SET_A: begin
            if (c < 7'd64) begin
              char_en   = 1'b1;
              char_base = c + 7'd32;
            end else if (c < 7'd96) begin
              char_en   = 1'b1;
              char_base = c - 7'd64;
            end else begin
              held_printable_next = 1'b0;
              case (c)
                c128d_pkg::SYM_FNC1:   fnc1_en = 1'b1;
                c128d_pkg::SYM_FNC4_A: fnc4_en = 1'b1;
                c128d_pkg::SYM_SHIFT: begin
                  unshift_pending_next = 1'b1;
                  code_set_next        = c128d_pkg::SET_B;
                end
                c128d_pkg::SYM_CODE_B: code_set_next = c128d_pkg::SET_B;
                c128d_pkg::SYM_CODE_C: code_set_next = c128d_pkg::SET_C;
                default: ;
              endcase
            end
          end
          c128d_pkg::SET_B: begin
            if (c < 7'd96) begin
              char_en   = 1'b1;
              char_base = c + 7'd32;
            end else begin
              held_printable_next = 1'b0;
              case (c)
                c128d_pkg::SYM_FNC1:   fnc1_en = 1'b1;
                c128d_pkg::SYM_FNC4_B: fnc4_en = 1'b1;
                c128d_pkg::SYM_SHIFT: begin
                  unshift_pending_next = 1'b1;
                  code_set_next        = c128d_pkg::SET_A;
                end
                c128d_pkg::SYM_CODE_A: code_set_next = c128d_pkg::SET_A;
                c128d_pkg::SYM_CODE_C: code_set_next = c128d_pkg::SET_C;
                default: ;
              endcase
            end
          end
          default: begin
            if (c < 7'd100) begin
              digits_en = 1'b1;
            end else begin
              held_printable_next = 1'b0;
              case (c)
                c128d_pkg::SYM_FNC1:   fnc1_en = 1'b1;
                c128d_pkg::SYM_CODE_A: code_set_next = c128d_pkg::SET_A;
                c128d_pkg::SYM_CODE_B: code_set_next = c128d_pkg::SET_B;
                default: ;
              endcase
            end
          end
        endcase

        // Bytes of this code, held until the next code shows it is not the
        // check character.
        if (char_en) begin
          hb0                 = {upper_one_shot ^ upper_latched, char_base};
          hold_n              = 2'd1;
          upper_one_shot_next = 1'b0;
        end
        if (digits_en) begin
          hb0    = c128d_pkg::BYTE_ZERO | {4'd0, digit_pair[7:4]};
          hb1    = c128d_pkg::BYTE_ZERO | {4'd0, digit_pair[3:0]};
          hold_n = 2'd2;
        end
        if (fnc1_en && gs1_mode) begin
          if (any_output) begin
            hb0    = c128d_pkg::BYTE_GS;
            hold_n = 2'd1;
          end else begin
            hb0    = c128d_pkg::BYTE_BRACKET;
            hb1    = c128d_pkg::BYTE_UPPER_C;
            hb2    = c128d_pkg::BYTE_ONE;
            hold_n = 2'd3;
          end
        end
        if (fnc4_en) begin
          if (upper_one_shot) begin
            // A second FNC4 in a row toggles the latched upper mode.
            upper_latched_next  = !upper_latched;
            upper_one_shot_next = 1'b0;
          end else begin
            upper_one_shot_next = 1'b1;
          end
        end

        held_bytes_next[0] = hb0;
        held_bytes_next[1] = hb1;
        held_bytes_next[2] = hb2;
        held_count_next    = hold_n;
        any_output_next    = any_output || (hold_n != 2'd0);

        // After a shifted code the set falls back to B from A, else to A.
        if (unshift_pending) begin
          code_set_next = (code_set_next == c128d_pkg::SET_A) ? c128d_pkg::SET_B
                                                              : c128d_pkg::SET_A;
        end
      end
    end
  end

  // Result transactions of this symbol: flushed bytes first, status after.
  assign nflush = flush ? held_count : 2'd0;
  assign load   = in_fire && ((nflush != 2'd0) || emit_status);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < nflush) begin
        slots_next[i].data = held_bytes[i];
        slots_next[i].kind = c128d_pkg::KIND_CHAR;
      end else begin
        slots_next[i].data = 8'd0;
        slots_next[i].kind = status_kind;
      end
    end
    slots_next[3].data = 8'd0;
    slots_next[3].kind = status_kind;
    count_next = {1'b0, nflush} + {2'd0, emit_status};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gs1_mode        <= 1'b0;
      active          <= 1'b0;
      code_set        <= c128d_pkg::SET_A;
      unshift_pending <= 1'b0;
      upper_latched   <= 1'b0;
      upper_one_shot  <= 1'b0;
      weight_mod      <= 7'd0;
      sum_before_last <= 7'd0;
      previous_value  <= 7'd0;
      prod_last       <= 14'd0;
      held_count      <= 2'd0;
      held_printable  <= 1'b1;
      any_output      <= 1'b0;
      count           <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gs1_mode <= cfg_data;
      end
      active          <= active_next;
      code_set        <= code_set_next;
      unshift_pending <= unshift_pending_next;
      upper_latched   <= upper_latched_next;
      upper_one_shot  <= upper_one_shot_next;
      weight_mod      <= weight_mod_next;
      sum_before_last <= sum_before_last_next;
      previous_value  <= previous_value_next;
      prod_last       <= prod_last_next;
      held_count      <= held_count_next;
      held_printable  <= held_printable_next;
      any_output      <= any_output_next;
      if (load) begin
        count <= count_next;
      end else if (out_fire) begin
        count <= count - 3'd1;
      end
    end
  end

  // Payload registers: held bytes and the result buffer entries.
  always_ff @(posedge clk) begin
    held_bytes <= held_bytes_next;
    if (load) begin
      slots <= slots_next;
    end else if (out_fire) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
      slots[2] <= slots[3];
    end
  end

endmodule

// ----- hw/rtl/c128d_checker.sv -----
// ----------------------------------------------------------------------------
// Code 128 symbol decoder port checker
// Watches the ports of the decoder and flags result transactions that break
// the ordering rules of the block.
// ----------------------------------------------------------------------------
module c128d_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [2:0] kind,
  input logic       last
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind) && $stable(last))
    else $error("result changed while stalled");

  // A status transaction carries no byte and always closes its symbol.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != c128d_pkg::KIND_CHAR) |-> last && (out_byte == 8'd0))
    else $error("status transaction not last or with a byte");

  // No new symbol is taken while more than one result is still waiting.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken with several results pending");

  // Reset empties the result buffer.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind code128_symbol_decoder c128d_checker u_c128d_checker (.*);
